[rtl/scrc_pkg.sv]
package scrc_pkg;

  localparam int unsigned TagW      = 32;
  localparam int unsigned DevW      = 8;
  localparam int unsigned TimeW     = 48;
  localparam int unsigned DeadlineW = TimeW + 1;
  localparam int unsigned CoolW     = 16;

  // event codes
  localparam logic [2:0] ACT_REQUEST  = 3'd0;
  localparam logic [2:0] ACT_FINISHED = 3'd1;
  localparam logic [2:0] ACT_STAMP    = 3'd2;
  localparam logic [2:0] ACT_CHECK    = 3'd3;
  localparam logic [2:0] ACT_TIMEOUT  = 3'd4;
  localparam logic [2:0] ACT_INVAL    = 3'd5;

  // phase codes
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_PENDING  = 2'd1;
  localparam logic [1:0] PH_WAITING  = 2'd2;
  localparam logic [1:0] PH_COOLDOWN = 2'd3;

  localparam logic [CoolW-1:0]     COOLDOWN_RESET = 16'd3000;
  localparam logic [TimeW-1:0]     STAMP_NEVER    = '1;
  localparam logic [DeadlineW-1:0] NO_DEADLINE    = '1;

  // register index of cooldown_ms
  localparam logic REG_COOLDOWN = 1'b0;

  typedef struct packed {
    logic [1:0]              phase;
    logic                    queued;
    logic [TagW-1:0]         generation;
    logic [DevW-1:0]         device;
    logic signed [TimeW-1:0] baseline;
    logic [DeadlineW-1:0]    deadline;
  } scrc_state_t;

  typedef struct packed {
    logic [2:0]              action;
    logic [TagW-1:0]         generation_tag;
    logic [DevW-1:0]         device_id;
    logic signed [TimeW-1:0] scan_stamp;
    logic [TimeW-1:0]        now_ms;
    logic                    success;
  } scrc_item_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] phase_now;
    logic       demand_queued;
  } scrc_result_t;

endpackage

[rtl/scrc_step.sv]
module scrc_step import scrc_pkg::*; (
  input  scrc_state_t      state,
  input  scrc_item_t       item,
  input  logic [CoolW-1:0] cooldown_ms,
  output scrc_state_t      state_next,
  output scrc_result_t     result
);

  logic [DeadlineW-1:0] cool_deadline;
  logic                 stamp_match;
  logic                 deadline_hit;
  logic                 acc;
  scrc_state_t          ns;

  // deadline if a cooldown starts now
  assign cool_deadline = {1'b0, item.now_ms} + {{(DeadlineW-CoolW){1'b0}}, cooldown_ms};

  assign stamp_match = (item.generation_tag == state.generation) &&
                       (item.device_id == state.device) &&
                       ($signed(item.scan_stamp) > $signed(state.baseline));

  assign deadline_hit = ({1'b0, item.now_ms} >= state.deadline);

  always_comb begin
    ns  = state;
    acc = 1'b0;
    unique case (item.action)
      ACT_REQUEST: begin
        acc = 1'b1;
        if (state.phase != PH_IDLE) begin
          ns.queued = 1'b1;
        end else begin
          ns.phase      = PH_PENDING;
          ns.queued     = 1'b0;
          ns.generation = item.generation_tag;
          ns.device     = item.device_id;
          ns.baseline   = item.scan_stamp;
          ns.deadline   = NO_DEADLINE;
        end
      end
      ACT_FINISHED: begin
        if (state.phase == PH_PENDING) begin
          if (item.success) begin
            ns.phase = PH_WAITING;
            acc      = 1'b1;
          end else if (state.queued) begin
            ns.phase    = PH_COOLDOWN;
            ns.deadline = cool_deadline;
          end else begin
            ns.phase  = PH_IDLE;
            ns.device = '0;
          end
        end
      end
      ACT_STAMP: begin
        if (state.phase == PH_WAITING && stamp_match) begin
          ns.phase    = PH_COOLDOWN;
          ns.deadline = cool_deadline;
          acc         = 1'b1;
        end
      end
      ACT_CHECK: begin
        if (state.phase == PH_COOLDOWN && deadline_hit) begin
          if (state.queued) begin
            ns.queued   = 1'b0;
            ns.baseline = STAMP_NEVER;
            acc         = 1'b1;
          end
          ns.phase    = PH_IDLE;
          ns.device   = '0;
          ns.deadline = NO_DEADLINE;
        end
      end
      ACT_TIMEOUT: begin
        if (state.phase == PH_PENDING || state.phase == PH_WAITING) begin
          if (state.queued) begin
            ns.phase    = PH_COOLDOWN;
            ns.deadline = cool_deadline;
          end else begin
            ns.phase    = PH_IDLE;
            ns.device   = '0;
            ns.baseline = STAMP_NEVER;
          end
        end
      end
      ACT_INVAL: begin
        ns.phase      = PH_IDLE;
        ns.queued     = 1'b0;
        ns.generation = '0;
        ns.device     = '0;
        ns.baseline   = STAMP_NEVER;
        ns.deadline   = NO_DEADLINE;
      end
      default: begin
        ns = state;
      end
    endcase
  end

  assign state_next           = ns;
  assign result.accepted      = acc;
  assign result.phase_now     = ns.phase;
  assign result.demand_queued = ns.queued;

endmodule

[rtl/scan_request_coalescer_unit.sv]
// registered path: an input transfer passes the input register, then the result register
// throughput: one event per cycle while results are taken; the event logic is a single pass of compares and one
//   49-bit add between the input register and the controller state / result register
// reset: synchronous active-high rst empties both stages, returns the controller to idle
//   with no queued demand, no baseline stamp and no deadline, and cooldown_ms to 3000
module scan_request_coalescer_unit import scrc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // event channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              action,
  input  logic [TagW-1:0]         generation_tag,
  input  logic [DevW-1:0]         device_id,
  input  logic signed [TimeW-1:0] scan_stamp,
  input  logic [TimeW-1:0]        now_ms,
  input  logic                    success,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    accepted,
  output logic [1:0]              phase_now,
  output logic                    demand_queued,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [CoolW-1:0] cooldown_ms;
  logic             cfg_write;
  logic             reg_sel;

  scrc_item_t   item;
  logic         item_valid;
  logic         item_adv;

  scrc_state_t  state;
  scrc_state_t  state_next;
  scrc_result_t step_result;

  // ---------------------------------------------------------------------------
  // configuration: one register at byte address 0, paddr[2] picks the register
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown_ms <= COOLDOWN_RESET;
    end else if (cfg_write && reg_sel == REG_COOLDOWN) begin
      cooldown_ms <= pwdata[CoolW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_COOLDOWN) begin
      prdata = {{(32-CoolW){1'b0}}, cooldown_ms};
    end
  end

  // ---------------------------------------------------------------------------
  // input register: the held event moves on whenever the result register is
  // free or its result is being taken in the same cycle
  // ---------------------------------------------------------------------------
  assign item_adv = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || item_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.action         <= action;
      item.generation_tag <= generation_tag;
      item.device_id      <= device_id;
      item.scan_stamp     <= scan_stamp;
      item.now_ms         <= now_ms;
      item.success        <= success;
    end
  end

  // ---------------------------------------------------------------------------
  // event logic: next controller state and the answer for the held event
  // ---------------------------------------------------------------------------
  scrc_step u_step (
    .state       (state),
    .item        (item),
    .cooldown_ms (cooldown_ms),
    .state_next  (state_next),
    .result      (step_result)
  );

  // controller state commits together with the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= PH_IDLE;
      state.queued     <= 1'b0;
      state.generation <= '0;
      state.device     <= '0;
      state.baseline   <= STAMP_NEVER;
      state.deadline   <= NO_DEADLINE;
    end else if (item_adv) begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_adv) begin
      accepted      <= step_result.accepted;
      phase_now     <= step_result.phase_now;
      demand_queued <= step_result.demand_queued;
    end
  end

endmodule

[rtl/scrc_checker.sv]
module scrc_checker import scrc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       accepted,
  input logic [1:0] phase_now,
  input logic       demand_queued,
  input logic       pready
);

  // result stage empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // an empty result side never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(accepted) &&
      $stable(phase_now) && $stable(demand_queued))
    else $error("stalled result changed");

  // demand is never left queued once the controller is back in idle
  a_idle_no_demand: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase_now == PH_IDLE |-> !demand_queued)
    else $error("demand queued while idle");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind scan_request_coalescer_unit scrc_checker u_scrc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .accepted      (accepted),
  .phase_now     (phase_now),
  .demand_queued (demand_queued),
  .pready        (pready)
);
